>>> sv/dufr_pkg.sv
// dufr_pkg: constants, codes and types shared by the dual uart frame receiver
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package dufr_pkg;

  // frame buffer depth used when the top level is not overridden
  localparam int unsigned BUFFER_DEPTH_DEFAULT = 128;

  // frame constants
  localparam logic [7:0] HDR_A     = 8'hA1;
  localparam logic [7:0] HDR_B     = 8'h02;
  localparam logic [7:0] TRAILER_B = 8'hFF;
  localparam int unsigned OVERHEAD_A = 3;
  localparam int unsigned OVERHEAD_B = 4;
  localparam int unsigned SAT_CAP    = 99;

  // widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned FMT_W       = 2;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 1;
  localparam int unsigned LEN_W       = 17;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_A = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_B = 2'd1;

  // format codes on format_used
  typedef enum logic [FMT_W-1:0] {
    FMT_A    = 2'd0,
    FMT_B    = 2'd1,
    FMT_NONE = 2'd2
  } fmt_t;

  // one classified byte as it travels from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              hdr_a;
    logic              hdr_b;
    logic              trailer;
  } word_t;

  // handshake of one word stage
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

>>> sv/dufr_front.sv
// dufr_front: accepts received bytes and tags header and trailer matches
// depends on dufr_pkg
`timescale 1ns / 1ps

module dufr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [dufr_pkg::BYTE_W-1:0]   rx_byte,
  input  logic                          rx_valid,
  output logic                          rx_ready,
  output dufr_pkg::word_t               word,
  output logic                          word_valid,
  input  logic                          word_ready
);
  import dufr_pkg::*;

  word_t classified;

  // tag the byte against the fixed codes
  always_comb begin
    classified.value   = rx_byte;
    classified.hdr_a   = (rx_byte == HDR_A);
    classified.hdr_b   = (rx_byte == HDR_B);
    classified.trailer = (rx_byte == TRAILER_B);
  end

  // input stage takes a new word whenever its content moves on
  assign rx_ready = !word_valid || word_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (rx_ready) begin
      word_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      word <= classified;
    end
  end

endmodule

>>> sv/dufr_queue.sv
// dufr_queue: short first-in first-out queue of classified words
// depends on dufr_pkg
`timescale 1ns / 1ps

module dufr_queue #(
  parameter int unsigned DEPTH = dufr_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  dufr_pkg::word_t in_word,
  input  logic            in_valid,
  output logic            in_ready,
  output dufr_pkg::word_t out_word,
  output dufr_pkg::hs_t   out_hs_fwd,
  input  logic            out_ready
);
  import dufr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  word_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic             push;
  logic             pop;

  assign in_ready         = (fill != FULL);
  assign out_hs_fwd.valid = (fill != '0);
  assign out_hs_fwd.ready = in_ready;
  assign out_word         = entries[rd_ptr];
  assign push             = in_valid && in_ready;
  assign pop              = out_hs_fwd.valid && out_ready;

  // fill level
  always_comb begin
    case ({push, pop})
      2'b10:   fill_next = fill + CNT_W'(1);
      2'b01:   fill_next = fill - CNT_W'(1);
      default: fill_next = fill;
    endcase
  end

  // pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_word;
    end
  end

endmodule

>>> sv/dufr_back.sv
// dufr_back: framing state for both formats, configuration registers, result register
// depends on dufr_pkg
`timescale 1ns / 1ps

module dufr_back #(
  parameter int unsigned BUFFER_DEPTH = dufr_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dufr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dufr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  dufr_pkg::word_t                     word,
  input  logic                                word_valid,
  output logic                                word_ready,
  output logic [dufr_pkg::BYTE_W-1:0]         byte_value,
  output logic                                byte_stored,
  output logic [dufr_pkg::COUNT_W-1:0]        store_index,
  output logic                                frame_done,
  output logic                                frame_error,
  output logic [dufr_pkg::FMT_W-1:0]          format_used,
  output logic                                res_valid,
  input  logic                                res_ready
);
  import dufr_pkg::*;

  localparam int unsigned SAT_LIMIT =
    ((BUFFER_DEPTH - 1) < SAT_CAP) ? (BUFFER_DEPTH - 1) : SAT_CAP;
  localparam logic [COUNT_W-1:0] SAT = COUNT_W'(SAT_LIMIT);
  localparam logic [LEN_W-1:0]   OVH_A = LEN_W'(OVERHEAD_A);
  localparam logic [LEN_W-1:0]   OVH_B = LEN_W'(OVERHEAD_B);
  localparam logic [COUNT_W-1:0] POS0 = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] POS1 = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] POS2 = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] POS3 = COUNT_W'(3);

  // configuration and framing state
  logic               enable_a;
  logic               enable_b;
  logic               b_stopped;
  logic [COUNT_W-1:0] count_a;
  logic [COUNT_W-1:0] count_b;
  logic [BYTE_W-1:0]  a_len_high;
  logic [BYTE_W-1:0]  a_len_low;
  logic [BYTE_W-1:0]  b_len_low;
  logic [BYTE_W-1:0]  b_len_high;

  logic               b_stopped_next;
  logic [COUNT_W-1:0] count_a_next;
  logic [COUNT_W-1:0] count_b_next;
  logic [BYTE_W-1:0]  a_len_high_next;
  logic [BYTE_W-1:0]  a_len_low_next;
  logic [BYTE_W-1:0]  b_len_low_next;
  logic [BYTE_W-1:0]  b_len_high_next;

  logic               stored_next;
  logic [COUNT_W-1:0] index_next;
  logic               done_next;
  logic               error_next;
  fmt_t               fmt_next;

  logic               take;
  logic [COUNT_W-1:0] inc_a;
  logic [COUNT_W-1:0] inc_b;
  logic [LEN_W-1:0]   end_a;
  logic [LEN_W-1:0]   end_b;
  logic               at_end_a;
  logic               at_end_b;

  // saturating increment of a store position
  function automatic logic [COUNT_W-1:0] next_pos(input logic [COUNT_W-1:0] c);
    logic [COUNT_W:0] n;
    n = {1'b0, c} + (COUNT_W + 1)'(1);
    if (n > {1'b0, SAT}) begin
      return SAT;
    end
    return n[COUNT_W-1:0];
  endfunction

  // the result register frees up when empty or taken
  assign word_ready = !res_valid || res_ready;
  assign take       = word_valid && word_ready;

  // end positions from the buffered length bytes
  assign inc_a    = next_pos(count_a);
  assign inc_b    = next_pos(count_b);
  assign end_a    = LEN_W'({a_len_high, a_len_low}) + OVH_A;
  assign end_b    = LEN_W'({b_len_high, b_len_low}) + OVH_B;
  assign at_end_a = (count_a >= POS2) && (LEN_W'(count_a) == end_a);
  assign at_end_b = (count_b >= POS2) && (LEN_W'(count_b) == end_b);

  // framing decision for the word at the head of the queue
  always_comb begin
    stored_next     = 1'b0;
    index_next      = '0;
    done_next       = 1'b0;
    error_next      = 1'b0;
    fmt_next        = FMT_NONE;
    count_a_next    = count_a;
    count_b_next    = count_b;
    a_len_high_next = a_len_high;
    a_len_low_next  = a_len_low;
    b_len_low_next  = b_len_low;
    b_len_high_next = b_len_high;
    b_stopped_next  = b_stopped;

    if (enable_a) begin
      fmt_next = FMT_A;
      if (count_a == POS0 && !word.hdr_a) begin
        error_next = 1'b1;
      end else if (count_a == POS1 && word.hdr_a) begin
        // repeated header restarts quietly
        count_a_next = '0;
      end else begin
        done_next    = at_end_a;
        stored_next  = 1'b1;
        index_next   = count_a;
        count_a_next = inc_a;
        if (count_a == POS2) begin
          a_len_high_next = word.value;
        end else if (count_a == POS3) begin
          a_len_low_next = word.value;
        end
      end
    end else if (enable_b && !b_stopped) begin
      fmt_next = FMT_B;
      if (count_b == POS0 && !word.hdr_b) begin
        error_next = 1'b1;
      end else if (count_b == POS1 && word.hdr_b) begin
        count_b_next = '0;
      end else if (at_end_b) begin
        if (word.trailer) begin
          done_next      = 1'b1;
          stored_next    = 1'b1;
          index_next     = count_b;
          b_stopped_next = 1'b1;
          count_b_next   = inc_b;
        end else begin
          // bad trailer drops the frame
          error_next   = 1'b1;
          count_b_next = '0;
        end
      end else begin
        stored_next  = 1'b1;
        index_next   = count_b;
        count_b_next = inc_b;
        if (count_b == POS1) begin
          b_len_low_next = word.value;
        end else if (count_b == POS2) begin
          b_len_high_next = word.value;
        end
      end
    end
  end

  // state registers and configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_a   <= 1'b0;
      enable_b   <= 1'b0;
      b_stopped  <= 1'b0;
      count_a    <= '0;
      count_b    <= '0;
      a_len_high <= '0;
      a_len_low  <= '0;
      b_len_low  <= '0;
      b_len_high <= '0;
    end else begin
      if (take) begin
        count_a    <= count_a_next;
        count_b    <= count_b_next;
        a_len_high <= a_len_high_next;
        a_len_low  <= a_len_low_next;
        b_len_low  <= b_len_low_next;
        b_len_high <= b_len_high_next;
        b_stopped  <= b_stopped_next;
      end
      if (cfg_we && cfg_index == REG_ENABLE_A) begin
        enable_a <= cfg_data[0];
      end
      if (cfg_we && cfg_index == REG_ENABLE_B) begin
        enable_b  <= cfg_data[0];
        b_stopped <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (word_ready) begin
      res_valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_value  <= word.value;
      byte_stored <= stored_next;
      store_index <= index_next;
      frame_done  <= done_next;
      frame_error <= error_next;
      format_used <= fmt_next;
    end
  end

endmodule

>>> sv/dual_uart_frame_receiver.sv
// dual_uart_frame_receiver: top level joining front stage, word queue and framing back end
// depends on dufr_pkg, dufr_front, dufr_queue, dufr_back
//
// Usage:
// - rx_byte/rx_valid/rx_ready carry received serial bytes, one word per byte.
// - Every byte gives exactly one result word on res_valid/res_ready with the
//   byte echoed, whether and where it is stored, frame done, frame error and
//   the format that handled it.
// - cfg_we/cfg_index/cfg_data write the two enables: index 0 format A,
//   index 1 format B; writing index 1 also re-arms format B after a frame.
//   Other indexes are ignored. Write only while no byte is in flight.
// - A result passes the input register, the queue and the result register,
//   in that order, after its byte is taken.
// - Throughput: one byte per cycle while the result side does not stall;
//   up to four bytes may be in flight.
// - Reset clears enables, counts, length bytes, the stop flag and all
//   handshake state; until an enable is written every byte is still taken
//   and answered with format none and nothing stored.
// - When the result side stalls, the result register holds, then the queue
//   fills, then rx_ready drops; no byte is lost or repeated.
`timescale 1ns / 1ps

module dual_uart_frame_receiver #(
  parameter int unsigned BUFFER_DEPTH = dufr_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dufr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dufr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [dufr_pkg::BYTE_W-1:0]       rx_byte,
  input  logic                              rx_valid,
  output logic                              rx_ready,
  output logic [dufr_pkg::BYTE_W-1:0]       byte_value,
  output logic                              byte_stored,
  output logic [dufr_pkg::COUNT_W-1:0]      store_index,
  output logic                              frame_done,
  output logic                              frame_error,
  output logic [dufr_pkg::FMT_W-1:0]        format_used,
  output logic                              res_valid,
  input  logic                              res_ready
);
  import dufr_pkg::*;

  localparam int unsigned SAT_LIMIT =
    ((BUFFER_DEPTH - 1) < SAT_CAP) ? (BUFFER_DEPTH - 1) : SAT_CAP;

  word_t front_word;
  logic  front_valid;
  logic  queue_in_ready;
  word_t head_word;
  hs_t   head_hs;
  logic  back_ready;

  // front stage
  dufr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx_byte    (rx_byte),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .word       (front_word),
    .word_valid (front_valid),
    .word_ready (queue_in_ready)
  );

  // decoupling queue
  dufr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .in_word    (front_word),
    .in_valid   (front_valid),
    .in_ready   (queue_in_ready),
    .out_word   (head_word),
    .out_hs_fwd (head_hs),
    .out_ready  (back_ready)
  );

  // framing back end
  dufr_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .word        (head_word),
    .word_valid  (head_hs.valid),
    .word_ready  (back_ready),
    .byte_value  (byte_value),
    .byte_stored (byte_stored),
    .store_index (store_index),
    .frame_done  (frame_done),
    .frame_error (frame_error),
    .format_used (format_used),
    .res_valid   (res_valid),
    .res_ready   (res_ready)
  );

  // a byte never both completes and breaks a frame
  a_done_xor_error: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(frame_done && frame_error))
    else $error("frame_done and frame_error together");

  // unstored bytes report position zero and no completion
  a_unstored_clean: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !byte_stored) |-> (store_index == '0 && !frame_done))
    else $error("unstored byte with index or done");

  // idle format touches nothing
  a_none_quiet: assert property (@(posedge clk) disable iff (rst)
    (res_valid && format_used == FMT_NONE) |-> (!byte_stored && !frame_error))
    else $error("activity with no format enabled");

  // store position stays within the saturation limit
  a_index_limit: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (32'(store_index) <= SAT_LIMIT))
    else $error("store_index beyond saturation limit");

  // a stalled result is held until taken
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(byte_value)
      && $stable(store_index)))
    else $error("result changed while stalled");

endmodule
